[hw/rtl/psf_pkg.sv]
// Shared constants for the pair sum finder.
`default_nettype none

package psf_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int VALUE_WIDTH_DEF   = 32;

  // Port field widths.
  localparam int IN_VALUE_W  = 32;
  localparam int CFG_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = 10;
  localparam int OUT_DATA_W  = 24;

  // Generation mark kept with each table entry; zero never marks a live entry.
  localparam int EPOCH_W = 8;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd3;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [IDX_W-1:0]    idx_t;

endpackage : psf_pkg

`default_nettype wire

[hw/rtl/pair_sum_finder.sv]
// Streaming two-sum finder built around a linear-probing hash table memory.
`default_nettype none

// Each input transfer carries one signed element in in_tdata and a new-array flag in
// in_tuser; each produces exactly one output transfer with a status, the index of the
// matching earlier element and the element's own index. The table lives in a single
// synchronous memory (one read and one write port) and is probed one entry per cycle.
// An element's time is set by the shared 32x32 hash multiplier and the serial probe
// loop, which takes an extra step for each further entry a lookup probes; when
// TABLE_ENTRIES is not a power of two, a restoring slot reduction follows each hash.
// Elements that only report "pair already found" or "over capacity" skip the hash and
// the probe. New arrays are opened with a generation mark instead of clearing the
// table, so after reset, and again on every 255th new-array flag, a clearing pass over
// all TABLE_ENTRIES slots runs while no element is accepted; configuration writes are
// taken at any time.
module pair_sum_finder #(
  parameter int TABLE_ENTRIES = psf_pkg::TABLE_ENTRIES_DEF,
  parameter int VALUE_WIDTH   = psf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write channel: target_sum.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [psf_pkg::CFG_W-1:0]       cfg_data,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [psf_pkg::IN_VALUE_W-1:0]  in_tdata,   // [31:0] value
  input  wire logic                            in_tuser,   // [0] first
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [psf_pkg::OUT_DATA_W-1:0]       out_tdata   // [1:0] status,
                                                           // [11:2] earlier_index,
                                                           // [21:12] current_index
);
  import psf_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int REM_W   = SLOT_W + 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int MEM_W   = EPOCH_W + IDX_W + VALUE_WIDTH;
  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_HASH  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_PROBE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Control registers.
  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pair_r, pair_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [SLOT_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                pend_r, pend_nxt;
  logic                phase_r, phase_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [2:0]          mod_cnt_r, mod_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] target_r, target_nxt;

  // Payload registers.
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [63:0]            prod_r, prod_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  idx_t                   cur_idx_r, cur_idx_nxt;
  idx_t                   earlier_r, earlier_nxt;
  status_t                status_r, status_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // Table memory.
  logic [MEM_W-1:0]  tbl_mem [TABLE_ENTRIES];
  logic [MEM_W-1:0]  rd_data_r;
  logic              mem_rd_en;
  logic [SLOT_W-1:0] mem_rd_addr;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wr_addr;
  logic [MEM_W-1:0]  mem_wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= tbl_mem[mem_rd_addr];
    end
  end

  // Entry fields from the registered read.
  logic [EPOCH_W-1:0]     ent_epoch;
  idx_t                   ent_idx;
  logic [VALUE_WIDTH-1:0] ent_val;
  logic                   ent_live;
  logic                   ent_hit;

  assign ent_epoch = rd_data_r[MEM_W-1 -: EPOCH_W];
  assign ent_idx   = rd_data_r[VALUE_WIDTH +: IDX_W];
  assign ent_val   = rd_data_r[VALUE_WIDTH-1:0];
  assign ent_live  = ent_epoch == epoch_r;
  assign ent_hit   = ent_live && (ent_val == key_r);

  // Hash multiplier operands: bits 63:32 of key * HASH_MULT built from
  // three 32x32 partial products.
  logic [63:0] key64;
  logic [31:0] mul_a, mul_b;
  logic [31:0] hash_val;

  assign key64    = 64'(key_r);
  assign mul_a    = (step_r == 2'd2) ? key64[63:32] : key64[31:0];
  assign mul_b    = (step_r == 2'd1) ? HASH_MULT[63:32] : HASH_MULT[31:0];
  assign hash_val = acc_r + prod_r[31:0];

  // Complement at one bit more than the value, so it never wraps.
  logic [VALUE_WIDTH:0] comp;
  logic                 comp_ok;
  logic                 in_cap;

  assign comp    = {target_r[VALUE_WIDTH-1], target_r} - {value_r[VALUE_WIDTH-1], value_r};
  assign comp_ok = comp[VALUE_WIDTH] == comp[VALUE_WIDTH-1];
  assign in_cap  = cnt_r < CNT_W'(TABLE_ENTRIES);

  logic out_load;
  logic [REM_W-1:0] rem_step;
  logic [31:0]      mod_bits;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pair_nxt      = pair_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    pend_nxt      = pend_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    mod_cnt_nxt   = mod_cnt_r;
    out_valid_nxt = out_valid_r;
    target_nxt    = target_r;
    value_nxt     = value_r;
    key_nxt       = key_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    slot_nxt      = slot_r;
    cur_idx_nxt   = cur_idx_r;
    earlier_nxt   = earlier_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = slot_r;
    mem_we        = 1'b0;
    mem_wr_addr   = slot_r;
    mem_wr_data   = {epoch_r, cur_idx_r, key_r};
    out_load      = 1'b0;
    rem_step      = rem_r;
    mod_bits      = acc_r;

    if (cfg_valid) begin
      target_nxt = VALUE_WIDTH'(cfg_data);
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_addr_r;
        mem_wr_data = '0;
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = pend_r ? S_START : S_IDLE;
          pend_nxt  = 1'b0;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          value_nxt = VALUE_WIDTH'(in_tdata);
          state_nxt = S_START;
          if (in_tuser) begin
            cnt_nxt  = '0;
            pair_nxt = 1'b0;
            // A new array takes a fresh generation; on wraparound the whole table
            // is wiped so that no stale mark can come back to life.
            if (epoch_r == '1) begin
              epoch_nxt    = EPOCH_W'(1);
              clr_addr_nxt = '0;
              pend_nxt     = 1'b1;
              state_nxt    = S_CLR;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end

      S_START: begin
        cur_idx_nxt = in_cap ? IDX_W'(cnt_r) : '0;
        earlier_nxt = '0;
        step_nxt    = '0;
        if (in_cap) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (pair_r) begin
          status_nxt = STAT_DONE;
          state_nxt  = S_DONE;
        end else if (!in_cap) begin
          status_nxt = STAT_OVER;
          state_nxt  = S_DONE;
        end else if (comp_ok) begin
          key_nxt   = comp[VALUE_WIDTH-1:0];
          phase_nxt = 1'b0;
          state_nxt = S_HASH;
        end else begin
          key_nxt   = value_r;
          phase_nxt = 1'b1;
          state_nxt = S_HASH;
        end
      end

      S_HASH: begin
        prod_nxt = mul_a * mul_b;
        step_nxt = step_r + 1'b1;
        case (step_r)
          2'd0: ;
          2'd1: acc_nxt = prod_r[63:32];
          2'd2: acc_nxt = hash_val;
          default: begin
            if (IS_POW2) begin
              slot_nxt    = hash_val[SLOT_W-1:0];
              mem_rd_en   = 1'b1;
              mem_rd_addr = hash_val[SLOT_W-1:0];
              state_nxt   = S_PROBE;
            end else begin
              acc_nxt     = hash_val;
              rem_nxt     = '0;
              mod_cnt_nxt = '0;
              state_nxt   = S_MOD;
            end
          end
        endcase
      end

      S_MOD: begin
        // Restoring remainder, four bits of the hash per cycle.
        for (int j = 0; j < 4; j++) begin
          rem_step = {rem_step[REM_W-2:0], mod_bits[31]};
          mod_bits = {mod_bits[30:0], 1'b0};
          if (rem_step >= REM_W'(TABLE_ENTRIES)) begin
            rem_step = rem_step - REM_W'(TABLE_ENTRIES);
          end
        end
        rem_nxt     = rem_step;
        acc_nxt     = mod_bits;
        mod_cnt_nxt = mod_cnt_r + 1'b1;
        if (mod_cnt_r == 3'd7) begin
          slot_nxt    = rem_step[SLOT_W-1:0];
          mem_rd_en   = 1'b1;
          mem_rd_addr = rem_step[SLOT_W-1:0];
          state_nxt   = S_PROBE;
        end
      end

      S_PROBE: begin
        if (ent_hit || !ent_live) begin
          if (!phase_r) begin
            if (ent_hit) begin
              status_nxt  = STAT_FOUND;
              earlier_nxt = ent_idx;
              pair_nxt    = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              key_nxt   = value_r;
              phase_nxt = 1'b1;
              step_nxt  = '0;
              state_nxt = S_HASH;
            end
          end else begin
            // Store or overwrite; the write lands before the next read of any item.
            mem_we     = 1'b1;
            status_nxt = STAT_NONE;
            state_nxt  = S_DONE;
          end
        end else begin
          slot_nxt    = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
          mem_rd_en   = 1'b1;
          mem_rd_addr = slot_nxt;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({cur_idx_r, earlier_r, status_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      pair_r      <= 1'b0;
      epoch_r     <= EPOCH_W'(1);
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      phase_r     <= 1'b0;
      step_r      <= '0;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pair_r      <= pair_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= pend_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      target_r    <= target_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    key_r      <= key_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    slot_r     <= slot_nxt;
    cur_idx_r  <= cur_idx_nxt;
    earlier_r  <= earlier_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The item counter saturates at the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("item counter beyond table size");

  // A found pair is remembered until the array ends.
  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (status_r == STAT_FOUND) |=> pair_r)
    else $error("pair flag not set after a found pair");

  // The pair flag only drops when a new array is started.
  a_pair_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pair_r) |-> $past(in_tvalid && in_tready && in_tuser))
    else $error("pair flag cleared without a new array");

  // Outside the clearing pass the live generation is never the cleared mark.
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR) |-> (epoch_r != '0))
    else $error("generation mark is zero");

endmodule : pair_sum_finder

`default_nettype wire

[bench/pair_sum_finder_tb.sv]
// Self-checking testbench for the streaming pair sum finder.
module pair_sum_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psf_pkg::*;

  localparam int SLOTS         = TABLE_ENTRIES_DEF;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int CHUNK_ITEMS   = 110;
  localparam int OPENINGS_GOAL = 520;

  localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    status_t status;
    idx_t    earlier;
    idx_t    current;
  } pair_result_t;

  typedef enum logic {ROW_ITEM, ROW_TARGET} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [31:0]  data;
    logic         start;
    logic         pinned;
    pair_result_t want;
  } script_row_t;

  typedef struct packed {
    logic         pinned;
    pair_result_t want;
  } pinned_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_VALUE_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Own copy of the block's table, counters and register.
  logic [31:0]        key_mem [SLOTS];
  idx_t               pos_mem [SLOTS];
  bit                 live_mem [SLOTS];
  int                 item_count = 0;
  bit                 pair_hit   = 1'b0;
  logic signed [31:0] target_now = '0;

  pinned_t      pinned_q [$];
  pair_result_t want_results [$];
  logic [31:0]  crowd_keys [$];
  logic [31:0]  corner_vals [6] = '{VAL_MAX, VAL_MIN, 32'd0, VAL_NEG1, 32'd1, 32'h8000_0001};

  int mismatches    = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;
  int arrays_opened = 0;
  int src_idle_pct  = 10;
  int dst_idle_pct  = 62;

  script_row_t script [24] = '{
    // No new-array flag after reset: the array is already open.
    '{ROW_ITEM,   32'd5,         1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'hFFFF_FFFB, 1'b0, 1'b1, '{STAT_FOUND, 10'd0, 10'd1}},
    '{ROW_ITEM,   32'd7,         1'b0, 1'b1, '{STAT_DONE,  10'd0, 10'd2}},
    // Complement of the most negative value does not fit, so it is a miss.
    '{ROW_ITEM,   VAL_MAX,       1'b1, 1'b1, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   VAL_MIN,       1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd1}},
    '{ROW_ITEM,   32'h8000_0001, 1'b0, 1'b1, '{STAT_FOUND, 10'd0, 10'd2}},
    '{ROW_TARGET, VAL_MAX,       1'b0, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   VAL_MIN,       1'b1, 1'b1, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   VAL_NEG1,      1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd1}},
    '{ROW_ITEM,   32'd0,         1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd2}},
    '{ROW_ITEM,   VAL_MAX,       1'b0, 1'b1, '{STAT_FOUND, 10'd2, 10'd3}},
    '{ROW_TARGET, VAL_MIN,       1'b0, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   VAL_MAX,       1'b1, 1'b1, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'd1,         1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd1}},
    '{ROW_ITEM,   VAL_NEG1,      1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd2}},
    '{ROW_ITEM,   VAL_MIN,       1'b0, 1'b1, '{STAT_NONE,  10'd0, 10'd3}},
    '{ROW_ITEM,   32'd0,         1'b0, 1'b1, '{STAT_FOUND, 10'd3, 10'd4}},
    '{ROW_TARGET, 32'd10,        1'b0, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    // A repeated value moves its entry to the newer index.
    '{ROW_ITEM,   32'd4,         1'b1, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'd4,         1'b0, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'd6,         1'b0, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'd5,         1'b0, 1'b0, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'd5,         1'b1, 1'b1, '{STAT_NONE,  10'd0, 10'd0}},
    '{ROW_ITEM,   32'd5,         1'b0, 1'b1, '{STAT_FOUND, 10'd0, 10'd1}}
  };

  pair_sum_finder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int home_slot_of(logic [31:0] key);
    logic [63:0] prod;
    prod = {32'd0, key} * HASH_MULT;
    return int'((prod >> 32) % SLOTS);
  endfunction

  // Linear probe: slot holding the key, else first empty slot, else SLOTS.
  function automatic int find_slot(logic [31:0] key, output bit hit);
    int s;
    s   = home_slot_of(key);
    hit = 1'b0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!live_mem[s]) return s;
      if (key_mem[s] == key) begin
        hit = 1'b1;
        return s;
      end
      s = (s + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  function automatic pair_result_t predict_pair(logic [31:0] v, logic start);
    pair_result_t       r;
    logic signed [32:0] comp;
    bit                 hit;
    bit                 in_cap;
    int                 s;
    if (start) begin
      foreach (live_mem[i]) live_mem[i] = 1'b0;
      item_count = 0;
      pair_hit   = 1'b0;
    end
    in_cap = item_count < SLOTS;
    r = '{STAT_NONE, '0, in_cap ? idx_t'(item_count) : '0};
    if (pair_hit) begin
      r.status = STAT_DONE;
    end else if (!in_cap) begin
      r.status = STAT_OVER;
    end else begin
      comp = $signed({target_now[31], target_now}) - $signed({v[31], v});
      // The complement can only be in the table if it fits the value width.
      if (comp[32] == comp[31]) begin
        s = find_slot(comp[31:0], hit);
        if (hit && s < SLOTS) begin
          r.status  = STAT_FOUND;
          r.earlier = pos_mem[s];
          pair_hit  = 1'b1;
        end
      end
      if (!pair_hit) begin
        s = find_slot(v, hit);
        if (s < SLOTS) begin
          key_mem[s]  = v;
          pos_mem[s]  = idx_t'(item_count);
          live_mem[s] = 1'b1;
        end
      end
    end
    if (in_cap) item_count++;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic push_item(logic [31:0] v, logic start, logic pinned, pair_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pinned_q.push_back('{pinned, want});
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= start;
    if (start) arrays_opened++;
    do @(posedge clk); while (!in_tready);
  endtask

  // Lets every outstanding result arrive, then gives the block time to finish its writes.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (want_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(logic [31:0] t);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    target_now = t;
  endtask

  // Mostly well-formed arrays that reuse earlier values and their complements,
  // with colliding keys and corner values mixed in; noisy ones break the framing.
  task automatic run_array(int len, bit noisy);
    logic [31:0] vals [$];
    logic [31:0] v;
    logic        start;
    int          r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (i > 0 && r < 25)      v = target_now - vals[$urandom_range(vals.size() - 1)];
      else if (i > 0 && r < 35) v = vals[$urandom_range(vals.size() - 1)];
      else if (r < 55)          v = crowd_keys[$urandom_range(crowd_keys.size() - 1)];
      else if (r < 65)          v = corner_vals[$urandom_range(5)];
      else                      v = $urandom;
      if (i == 0) start = noisy ? 1'($urandom_range(1)) : 1'b1;
      else        start = noisy && ($urandom_range(19) == 0);
      push_item(v, start, 1'b0, '0);
      vals.push_back(v);
    end
  endtask

  // Fills a whole array with no pair but, if asked, its last in-range item with the
  // first. Each in-range value but that closing one gets its own home slot so the
  // probe chains stay short; a few items past the capacity follow.
  task automatic long_array(bit end_in_pair);
    bit                 slot_taken [SLOTS];
    bit                 seen [int];
    logic [31:0]        v;
    logic [31:0]        lead;
    logic signed [32:0] comp;
    bit                 ok;
    for (int i = 0; i < SLOTS; i++) begin
      if (end_in_pair && i == SLOTS - 1) begin
        v = target_now - lead;
      end else begin
        do begin
          v    = $urandom;
          comp = $signed({target_now[31], target_now}) - $signed({v[31], v});
          ok   = !slot_taken[home_slot_of(v)] &&
                 (comp[32] != comp[31] || !seen.exists(int'(comp[31:0])));
          if (end_in_pair && i == 0) ok = ok && (comp[32] == comp[31]);
        end while (!ok);
        slot_taken[home_slot_of(v)] = 1'b1;
      end
      if (i == 0) lead = v;
      seen[int'(v)] = 1'b1;
      push_item(v, i == 0, 1'b0, '0);
    end
    repeat (3) push_item($urandom, 1'b0, 1'b0, '0);
  endtask

  always @(posedge clk) out_tready <= rst_n && ($urandom_range(99) >= dst_idle_pct);

  always @(posedge clk) begin
    pinned_t      tag;
    pair_result_t guess;
    pair_result_t got;
    pair_result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      tag   = pinned_q.pop_front();
      guess = predict_pair(in_tdata, in_tuser);
      want_results.push_back(tag.pinned ? tag.want : guess);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[1:0], out_tdata[11:2], out_tdata[21:12]};
      results_seen++;
      if (want_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = want_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    results_seen, got.status, want.status));
        if (got.earlier !== want.earlier)
          report_mismatch($sformatf("result %0d: earlier_index %0d, expected %0d",
                                    results_seen, got.earlier, want.earlier));
        if (got.current !== want.current)
          report_mismatch($sformatf("result %0d: current_index %0d, expected %0d",
                                    results_seen, got.current, want.current));
      end
    end
  end

  // Ends a hung run: counts cycles in which no transfer happens on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("pair_sum_finder_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] targets [9];
    logic [31:0] base;
    logic [31:0] k;
    int          h;
    int          got;
    int          sent;
    int          len;
    targets = '{32'd0, VAL_MAX, VAL_MIN, $urandom, VAL_NEG1, 32'd1,
                $urandom, $urandom, $urandom};
    // Groups of keys that share a home slot or its neighbor, to force probing.
    for (int g = 0; g < 4; g++) begin
      base = $urandom;
      h    = home_slot_of(base);
      crowd_keys.push_back(base);
      got  = 1;
      while (got < 4) begin
        k = $urandom;
        if (home_slot_of(k) == h || home_slot_of(k) == (h + 1) % SLOTS) begin
          crowd_keys.push_back(k);
          got++;
        end
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_TARGET) begin
        settle();
        write_target(script[i].data);
      end else begin
        push_item(script[i].data, script[i].start, script[i].pinned, script[i].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 62 : 0;
      dst_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 10 : 0;
      for (int chunk = 0; chunk < 3; chunk++) begin
        settle();
        write_target(targets[phase * 3 + chunk]);
        if (chunk == 0 && phase < 2) long_array(phase == 1);
        sent = 0;
        while (sent < CHUNK_ITEMS) begin
          len = ($urandom_range(99) < 40) ? $urandom_range(1, 2) : $urandom_range(3, 16);
          run_array(len, $urandom_range(99) < 20);
          sent += len;
        end
      end
    end

    // Many short arrays so the periodic table clearing comes around more than once.
    while (arrays_opened < OPENINGS_GOAL) run_array($urandom_range(1, 2), 1'b0);

    settle();
    if (mismatches == 0 && want_results.size() == 0) begin
      $display("pair_sum_finder_tb: done, clean");
    end else begin
      $display("pair_sum_finder_tb: done, errors");
    end
    $finish;
  end

endmodule
